// File: rtl/core/tcdx_pkg.sv
// ----------------------------------------------------------------------------
// tcdx_pkg
// Shared types and constants for the tagged chunk deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcdx_pkg;

   // Tags as they appear on the wire, first character in the low byte
   localparam logic [31:0] MAGIC_FILE = 32'h3543_4553;   // "SEC5"
   localparam logic [31:0] MAGIC_CODE = 32'h4544_4F43;   // "CODE"
   localparam logic [31:0] MAGIC_ENDS = 32'h5344_4E45;   // "ENDS"
   localparam logic [7:0]  KEY_STEP   = 8'h12;

   localparam logic [2:0]  HDR_LAST   = 3'd7;

   // Parser phase codes
   localparam logic [1:0]  PH_FILE    = 2'd0;
   localparam logic [1:0]  PH_CHUNK   = 2'd1;
   localparam logic [1:0]  PH_DATA    = 2'd2;
   localparam logic [1:0]  PH_ERROR   = 2'd3;

   // Status codes
   localparam logic        ST_OK      = 1'b0;
   localparam logic        ST_BAD_MAG = 1'b1;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] chunk_tag;
      logic        has_data;
      logic        last_of_chunk;
      logic        status;
   } tcdx_rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/tcdx_if.sv
// ----------------------------------------------------------------------------
// tcdx_if
// Valid/ready channels for archive bytes in and deframed results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcdx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_of_file;

   modport source (output valid, output in_byte, output start_of_file, input ready);
   modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

interface tcdx_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [31:0] chunk_tag;
   logic        has_data;
   logic        last_of_chunk;
   logic        status;

   modport source (output valid, output out_byte, output chunk_tag, output has_data,
                   output last_of_chunk, output status, input ready);
   modport sink   (input valid, input out_byte, input chunk_tag, input has_data,
                   input last_of_chunk, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tcdx_parser.sv
// ----------------------------------------------------------------------------
// tcdx_parser
// Header collection, payload counting and XOR stream key, one accepted byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcdx_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  start_of_file,
   output logic                       emit,
   output tcdx_pkg::tcdx_rsp_type     rsp
);
   import tcdx_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  key_ff, key_in;
   logic        decrypt_ff, decrypt_in;

   // state as seen by this byte (start of file restarts the parser)
   logic [1:0]  cur_phase;
   logic [2:0]  cur_hcount;
   logic [31:0] cur_tag, cur_size, cur_remain, hdr_tag, hdr_size, rem_dec;
   logic [7:0]  cur_key;
   logic        cur_decrypt, hdr_done;

   always_comb begin
      cur_phase   = start_of_file ? PH_FILE : phase_ff;
      cur_hcount  = start_of_file ? 3'd0    : hcount_ff;
      cur_tag     = start_of_file ? 32'd0   : tag_ff;
      cur_size    = start_of_file ? 32'd0   : size_ff;
      cur_remain  = start_of_file ? 32'd0   : remain_ff;
      cur_key     = start_of_file ? 8'd0    : key_ff;
      cur_decrypt = start_of_file ? 1'b0    : decrypt_ff;

      hdr_tag  = cur_tag;
      hdr_size = cur_size;
      if (!cur_hcount[2]) begin
         hdr_tag[{cur_hcount[1:0], 3'b000} +: 8] = in_byte;
      end else begin
         hdr_size[{cur_hcount[1:0], 3'b000} +: 8] = in_byte;
      end
      hdr_done = (cur_hcount == HDR_LAST);
      rem_dec  = cur_remain - 32'd1;

      phase_in   = phase_ff;
      hcount_in  = hcount_ff;
      tag_in     = tag_ff;
      size_in    = size_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      decrypt_in = decrypt_ff;

      emit              = 1'b0;
      rsp.out_byte      = 8'd0;
      rsp.chunk_tag     = cur_tag;
      rsp.has_data      = 1'b0;
      rsp.last_of_chunk = 1'b0;
      rsp.status        = ST_OK;

      if (accept) begin
         phase_in   = cur_phase;
         hcount_in  = cur_hcount;
         tag_in     = cur_tag;
         size_in    = cur_size;
         remain_in  = cur_remain;
         key_in     = cur_key;
         decrypt_in = cur_decrypt;

         case (cur_phase)
            PH_FILE, PH_CHUNK: begin
               tag_in        = hdr_tag;
               size_in       = hdr_size;
               hcount_in     = hdr_done ? 3'd0 : cur_hcount + 3'd1;
               rsp.chunk_tag = hdr_tag;
               if (hdr_done) begin
                  if (cur_phase == PH_FILE) begin
                     if (hdr_tag != MAGIC_FILE) begin
                        phase_in   = PH_ERROR;
                        emit       = 1'b1;
                        rsp.status = ST_BAD_MAG;
                     end else begin
                        phase_in = PH_CHUNK;
                     end
                  end else if (hdr_tag != MAGIC_ENDS) begin
                     if (hdr_size == 32'd0) begin
                        // empty chunk marker
                        emit              = 1'b1;
                        rsp.last_of_chunk = 1'b1;
                     end else begin
                        remain_in  = hdr_size;
                        key_in     = 8'd0;
                        decrypt_in = (hdr_tag == MAGIC_CODE);
                        phase_in   = PH_DATA;
                     end
                  end
               end
            end
            PH_DATA: begin
               emit              = 1'b1;
               rsp.has_data      = 1'b1;
               rsp.out_byte      = cur_decrypt ? (in_byte ^ cur_key) : in_byte;
               rsp.last_of_chunk = (rem_dec == 32'd0);
               key_in            = cur_key + in_byte + KEY_STEP;
               remain_in         = rem_dec;
               if (rem_dec == 32'd0) begin
                  phase_in  = PH_CHUNK;
                  hcount_in = 3'd0;
               end
            end
            default: begin
               // error phase: drop bytes until the next start of file
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FILE;
         hcount_ff  <= 3'd0;
         tag_ff     <= 32'd0;
         size_ff    <= 32'd0;
         remain_ff  <= 32'd0;
         key_ff     <= 8'd0;
         decrypt_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hcount_ff  <= hcount_in;
         tag_ff     <= tag_in;
         size_ff    <= size_in;
         remain_ff  <= remain_in;
         key_ff     <= key_in;
         decrypt_ff <= decrypt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tcdx_out_reg.sv
// ----------------------------------------------------------------------------
// tcdx_out_reg
// Result register; takes a new result in the cycle the old one transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcdx_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire tcdx_pkg::tcdx_rsp_type data,
   output logic                       free,
   tcdx_rsp_if.source                 rsp_chan
);
   import tcdx_pkg::*;

   logic         valid_ff, valid_in;
   tcdx_rsp_type data_ff, data_in;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);
   assign data_in  = load ? data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.out_byte      = data_ff.out_byte;
   assign rsp_chan.chunk_tag     = data_ff.chunk_tag;
   assign rsp_chan.has_data      = data_ff.has_data;
   assign rsp_chan.last_of_chunk = data_ff.last_of_chunk;
   assign rsp_chan.status        = data_ff.status;

endmodule

`default_nettype wire

// File: rtl/core/tagged_chunk_deframer_xor_decrypt.sv
// ----------------------------------------------------------------------------
// tagged_chunk_deframer_xor_decrypt
// Deframes a tagged chunk archive byte by byte and decrypts CODE chunks.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one archive byte per transfer; start_of_file marks the
//   first byte of an archive and restarts the parser on that byte.
//   rsp_chan carries at most one result per input byte: a payload byte with
//   its chunk tag, an empty-chunk marker, or a bad-magic error.
//   Only a header's last byte can give a result; bytes after a bad magic give none.
//   Results are registered and reach rsp_chan the cycle after their byte transfers.
//   Throughput: one byte per cycle; the parser state updates in the cycle a
//   byte is taken and the result register frees in the cycle it transfers.
//   When the receiver stalls, the result holds and req_chan.ready drops until
//   the held result transfers.
//   Reset returns the parser to the file header and empties the result
//   register.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_chunk_deframer_xor_decrypt (
   input  wire logic  clock,
   input  wire logic  reset,
   tcdx_req_if.sink   req_chan,
   tcdx_rsp_if.source rsp_chan
);
   import tcdx_pkg::*;

   logic         free;
   logic         accept;
   logic         emit;
   tcdx_rsp_type rsp;

   assign req_chan.ready = free;
   assign accept         = req_chan.valid && free;

   tcdx_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_chan.in_byte),
      .start_of_file (req_chan.start_of_file),
      .emit          (emit),
      .rsp           (rsp)
   );

   tcdx_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (emit),
      .data     (rsp),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: dv/tb_tagged_chunk_deframer_xor_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_chunk_deframer_xor_decrypt
// Self-checking bench for the chunk deframer and XOR decrypter. It streams
// archives one byte per transfer, both well formed and broken, and predicts
// each result from its own copy of the parser state. Results are checked in
// order at the output.
// ----------------------------------------------------------------------------

module tb_tagged_chunk_deframer_xor_decrypt;
   import tcdx_pkg::*;

   localparam int ITEMS_TOTAL   = 1050;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       sof;
      logic [6:0] gap_pct;
      logic [6:0] stall_pct;
      logic       drain;
   } archive_byte_type;

   logic clock;
   logic reset;

   tcdx_req_if req_chan ();
   tcdx_rsp_if rsp_chan ();

   tagged_chunk_deframer_xor_decrypt dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   archive_byte_type archive_bytes[$];
   tcdx_rsp_type     deframed_due[$];

   int          bytes_built;
   int          bytes_taken;
   int          failures;
   int          cycle_count;
   logic [6:0]  rx_stall_pct;
   logic        hold_for_drain;

   // Predicted parser state
   logic [1:0]  ps_phase;
   logic [2:0]  ps_hdr_cnt;
   logic [31:0] ps_tag;
   logic [31:0] ps_size;
   logic [31:0] ps_remaining;
   logic [7:0]  ps_key;
   logic        ps_decrypt;

   // Sender idle and receiver stall odds per phase of the run
   logic [6:0]  gap_by_phase   [4] = '{7'd0, 7'd64, 7'd0,  7'd14};
   logic [6:0]  stall_by_phase [4] = '{7'd0, 7'd0,  7'd64, 7'd14};

   initial begin
      clock                  = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.in_byte       = 8'h00;
      req_chan.start_of_file = 1'b0;
      rsp_chan.ready         = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   task automatic deframe_byte(input logic [7:0] b, input logic sof);
      tcdx_rsp_type r;
      logic         hdr_done;
      logic [7:0]   plain;
      int           sh;
      if (sof) begin
         ps_phase     = PH_FILE;
         ps_hdr_cnt   = 3'd0;
         ps_tag       = 32'd0;
         ps_size      = 32'd0;
         ps_remaining = 32'd0;
         ps_key       = 8'd0;
         ps_decrypt   = 1'b0;
      end
      hdr_done = 1'b0;
      r        = '0;
      if (ps_phase == PH_FILE || ps_phase == PH_CHUNK) begin
         sh = 8 * int'(ps_hdr_cnt[1:0]);
         if (ps_hdr_cnt[2])
            ps_size[sh +: 8] = b;
         else
            ps_tag[sh +: 8] = b;
         hdr_done   = (ps_hdr_cnt == HDR_LAST);
         ps_hdr_cnt = hdr_done ? 3'd0 : ps_hdr_cnt + 3'd1;
      end
      case (ps_phase)
         PH_FILE: begin
            if (hdr_done) begin
               if (ps_tag != MAGIC_FILE) begin
                  ps_phase    = PH_ERROR;
                  r.chunk_tag = ps_tag;
                  r.status    = ST_BAD_MAG;
                  deframed_due.push_back(r);
               end else begin
                  ps_phase = PH_CHUNK;
               end
            end
         end
         PH_CHUNK: begin
            // ENDS is a bare header: its size is dropped
            if (hdr_done && ps_tag != MAGIC_ENDS) begin
               if (ps_size == 32'd0) begin
                  r.chunk_tag     = ps_tag;
                  r.last_of_chunk = 1'b1;
                  r.status        = ST_OK;
                  deframed_due.push_back(r);
               end else begin
                  ps_remaining = ps_size;
                  ps_key       = 8'd0;
                  ps_decrypt   = (ps_tag == MAGIC_CODE);
                  ps_phase     = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            plain        = ps_decrypt ? (b ^ ps_key) : b;
            ps_key       = ps_key + b + KEY_STEP;
            ps_remaining = ps_remaining - 32'd1;
            r.out_byte      = plain;
            r.chunk_tag     = ps_tag;
            r.has_data      = 1'b1;
            r.last_of_chunk = (ps_remaining == 32'd0);
            r.status        = ST_OK;
            if (ps_remaining == 32'd0) begin
               ps_phase   = PH_CHUNK;
               ps_hdr_cnt = 3'd0;
            end
            deframed_due.push_back(r);
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Archive builder
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic sof);
      archive_byte_type item;
      int               ph;
      ph = (bytes_built * 4) / ITEMS_TOTAL;
      if (ph > 3) ph = 3;
      item.data      = b;
      item.sof       = sof;
      item.gap_pct   = gap_by_phase[ph];
      item.stall_pct = stall_by_phase[ph];
      item.drain     = hold_for_drain;
      hold_for_drain = 1'b0;
      archive_bytes.push_back(item);
      bytes_built++;
   endtask

   task automatic put_header(input logic [31:0] tag, input logic [31:0] size,
                             input logic sof);
      for (int i = 0; i < 4; i++) push_byte(tag[8*i +: 8], sof && i == 0);
      for (int i = 0; i < 4; i++) push_byte(size[8*i +: 8], 1'b0);
   endtask

   task automatic put_random_archive();
      int          kind;
      int          sz;
      int          cut;
      logic [31:0] tag;
      if ($urandom_range(11) == 0) hold_for_drain = 1'b1;

      // Bad magic, sometimes one bit off, then a few dropped bytes
      if ($urandom_range(9) == 0) begin
         tag = $urandom_range(1) ? MAGIC_FILE ^ (32'd1 << $urandom_range(31)) : $urandom;
         put_header(tag, $urandom, 1'b1);
         repeat ($urandom_range(6)) push_byte(8'($urandom), 1'b0);
         return;
      end

      // Header cut short by the next start of file
      if ($urandom_range(24) == 0) begin
         cut = $urandom_range(1, 7);
         for (int i = 0; i < cut; i++)
            push_byte(i < 4 ? MAGIC_FILE[8*i +: 8] : 8'($urandom), i == 0);
         return;
      end

      put_header(MAGIC_FILE, $urandom, 1'b1);
      repeat ($urandom_range(1, 5)) begin
         kind = $urandom_range(9);
         case (kind)
            0, 1, 2, 3: tag = MAGIC_CODE;
            4:          tag = MAGIC_ENDS;
            9:          tag = MAGIC_CODE ^ (32'd1 << $urandom_range(31));
            default:    tag = $urandom;
         endcase
         if (tag == MAGIC_ENDS) begin
            put_header(tag, $urandom, 1'b0);
         end else if ($urandom_range(19) == 0) begin
            // Huge size, payload cut short by the next archive
            put_header(tag, $urandom | 32'h0100_0000, 1'b0);
            repeat ($urandom_range(10)) push_byte(8'($urandom), 1'b0);
            return;
         end else if ($urandom_range(29) == 0) begin
            // Chunk header cut short
            cut = $urandom_range(1, 7);
            for (int i = 0; i < cut; i++) push_byte(i < 4 ? tag[8*i +: 8] : 8'h00, 1'b0);
            return;
         end else begin
            sz = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 16);
            put_header(tag, sz, 1'b0);
            repeat (sz) push_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: one archive byte per transfer, predicted on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      archive_byte_type nxt;
      logic             take;
      if (reset) begin
         req_chan.valid <= 1'b0;
         rx_stall_pct   <= 7'd0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            deframe_byte(req_chan.in_byte, req_chan.start_of_file);
            bytes_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            take = 1'b0;
            if (archive_bytes.size() > 0) begin
               if (archive_bytes[0].drain) begin
                  if (deframed_due.size() == 0) archive_bytes[0].drain = 1'b0;
               end else if ($urandom_range(99) >= archive_bytes[0].gap_pct) begin
                  nxt  = archive_bytes.pop_front();
                  take = 1'b1;
               end
            end
            req_chan.valid <= take;
            if (take) begin
               req_chan.in_byte       <= nxt.data;
               req_chan.start_of_file <= nxt.sof;
               rx_stall_pct           <= nxt.stall_pct;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      tcdx_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (deframed_due.size() == 0) begin
               $error("unexpected result: tag 0x%0h byte 0x%0h",
                      rsp_chan.chunk_tag, rsp_chan.out_byte);
               failures++;
            end else begin
               want = deframed_due.pop_front();
               check_field("out_byte", 32'(want.out_byte), 32'(rsp_chan.out_byte));
               check_field("chunk_tag", want.chunk_tag, rsp_chan.chunk_tag);
               check_field("has_data", 32'(want.has_data), 32'(rsp_chan.has_data));
               check_field("last_of_chunk", 32'(want.last_of_chunk),
                           32'(rsp_chan.last_of_chunk));
               check_field("status", 32'(want.status), 32'(rsp_chan.status));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      bytes_built    = 0;
      bytes_taken    = 0;
      failures       = 0;
      cycle_count    = 0;
      hold_for_drain = 1'b0;
      ps_phase       = PH_FILE;
      ps_hdr_cnt     = 3'd0;
      ps_tag         = 32'd0;
      ps_size        = 32'd0;
      ps_remaining   = 32'd0;
      ps_key         = 8'd0;
      ps_decrypt     = 1'b0;

      // Directed: first archive relies on reset alone, no start flag
      put_header(MAGIC_FILE, 32'hFFFF_FFFF, 1'b0);
      put_header(MAGIC_CODE, 32'd3, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hA5, 1'b0);
      put_header(32'hFFFF_FFFF, 32'd0, 1'b0);    // empty chunk marker
      put_header(MAGIC_ENDS, 32'h8000_0007, 1'b0);
      put_header(32'h0000_0000, 32'd0, 1'b1);    // bad magic
      push_byte(8'hFF, 1'b0);                    // dropped

      // Random archives; the first one waits for the pipe to drain
      hold_for_drain = 1'b1;
      while (bytes_built < ITEMS_TOTAL) put_random_archive();

      while (bytes_taken < bytes_built) @(posedge clock);
      while (deframed_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
